/* sv/moore_boundary_tracer_macros.svh */
// Assertion macros for the Moore boundary tracer RTL.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef MOORE_BOUNDARY_TRACER_MACROS_SVH
`define MOORE_BOUNDARY_TRACER_MACROS_SVH

// same-cycle implication, checked out of reset
`define MBT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MBT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mbt_pkg.sv */
// Shared types, constants and neighbour ring tables for the boundary tracer.
// No dependencies.
package mbt_pkg;

	localparam int IMAGE_WIDTH  = 64;
	localparam int IMAGE_HEIGHT = 64;
	localparam int IMG_DEPTH    = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int XW           = $clog2(IMAGE_WIDTH);
	localparam int YW           = $clog2(IMAGE_HEIGHT);
	localparam int ADDR_W       = $clog2(IMG_DEPTH);
	localparam int PT_W         = 6;   // width of the coordinate ports
	localparam int RING_CNT_W   = 4;   // holds 0..8

	localparam logic [0:0] OP_WRITE = 1'b0;
	localparam logic [0:0] OP_STEP  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_TOPLEFT  = 2'd2;
	localparam logic [1:0] ST_FINISHED = 2'd3;

	// ring positions, clockwise from left
	localparam logic [2:0] DIR_LEFT = 3'd0;
	localparam logic [2:0] DIR_TOP  = 3'd2;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_TRACE = 2'd1,
		PH_DONE  = 2'd2
	} phase_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic              data;
	} mbt_wr_t;

	function automatic logic signed [1:0] ring_dx(input logic [2:0] d);
		logic signed [1:0] r;
		case (d)
			3'd0, 3'd1, 3'd7: r = -2'sd1;
			3'd3, 3'd4, 3'd5: r = 2'sd1;
			default:          r = 2'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] ring_dy(input logic [2:0] d);
		logic signed [1:0] r;
		case (d)
			3'd1, 3'd2, 3'd3: r = -2'sd1;
			3'd5, 3'd6, 3'd7: r = 2'sd1;
			default:          r = 2'sd0;
		endcase
		return r;
	endfunction

	// backtrack seen from the new point after a move in direction d
	function automatic logic [2:0] next_back(input logic [2:0] d);
		logic [2:0] r;
		case (d)
			3'd0, 3'd1: r = 3'd6;
			3'd2, 3'd3: r = 3'd0;
			3'd4, 3'd5: r = 3'd2;
			default:    r = 3'd4;
		endcase
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [XW-1:0] x,
			input logic [YW-1:0] y);
		return ADDR_W'(ADDR_W'(y) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(x));
	endfunction

endpackage

/* sv/mbt_pixel_mem.sv */
// One-bit-wide image memory with registered read and a clearing sweep after reset.
// Depends on mbt_pkg.
module mbt_pixel_mem import mbt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mbt_wr_t           wr,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic              rd_data,
	output logic              busy
);

	logic              mem [IMG_DEPTH];
	logic [ADDR_W-1:0] clr_q;
	logic              busy_q;
	logic              rd_data_q;

	// clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == ADDR_W'(IMG_DEPTH - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q)
			mem[clr_q] <= 1'b0;
		else if (wr.en)
			mem[wr.addr] <= wr.data;
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

/* sv/moore_boundary_tracer.sv */
// Moore-neighbour boundary tracer over a 64 x 64 binary image held in a one-bit memory.
// A write beat (operation 0) sets one pixel and returns the trace to idle; a step beat
// (operation 1) returns one result beat: a contour point, or a status when there is none.
// The first step after idle walks the raster one pixel a cycle through the memory read
// port and then scans the ring of the start pixel; an empty image answers with status
// empty and a set top-left pixel with status top-left, both without a ring scan.
// Every further step scans the clockwise ring of eight neighbours, one memory read a
// cycle. A step on a finished trace answers with status finished. After reset the memory
// is swept clear, all IMAGE_WIDTH*IMAGE_HEIGHT (4096) entries, and in_ready stays low
// meanwhile. One item is worked on at a time; a finished result sits in the output
// register while the next beat is taken.
// Depends on mbt_pkg, mbt_pixel_mem and moore_boundary_tracer_macros.svh.
`include "moore_boundary_tracer_macros.svh"

module moore_boundary_tracer import mbt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            operation,
	input  logic [5:0]      pixel_x,
	input  logic [5:0]      pixel_y,
	input  logic            pixel_on,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [PT_W-1:0] point_x,
	output logic [PT_W-1:0] point_y,
	output logic            last_point,
	output logic [1:0]      status
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,   // raster search for the start pixel
		S_RING = 4'b0100,   // clockwise neighbour scan
		S_EMIT = 4'b1000    // hand result to output register
	} state_t;

	state_t  st_q;
	phase_t  phase_q;

	logic [XW-1:0] cur_x_q, start_x_q;
	logic [YW-1:0] cur_y_q, start_y_q;
	logic [2:0]    bt_q;

	// raster scan: issue stage counters, check stage copies
	logic [XW-1:0] scan_x_q, scan_x_s1;
	logic [YW-1:0] scan_y_q, scan_y_s1;
	logic          scan_vld_s1, scan_last_s1;

	// ring scan
	logic [2:0]            ring_d_q, ring_d_s1;
	logic [RING_CNT_W-1:0] ring_cnt_q;
	logic                  ring_vld_s1, ring_inb_s1, ring_last_s1;
	logic [XW-1:0]         ring_x_s1;
	logic [YW-1:0]         ring_y_s1;

	// pending result
	logic [PT_W-1:0] res_x_q, res_y_q;
	logic            res_last_q;
	logic [1:0]      res_stat_q;

	// output register
	logic            out_valid_q;
	logic [PT_W-1:0] point_x_q, point_y_q;
	logic            last_point_q;
	logic [1:0]      status_q;

	logic              mem_busy, mem_rd_data;
	logic [ADDR_W-1:0] mem_rd_addr;
	mbt_wr_t           mem_wr;

	logic              in_fire, out_fire, wr_in_range;
	logic signed [1:0] dx, dy;
	logic [XW-1:0]     nx;
	logic [YW-1:0]     ny;
	logic              n_inb;
	logic              scan_last_now, ring_hit;
	logic [XW-1:0]     new_x;
	logic [YW-1:0]     new_y;

	assign in_ready = (st_q == S_IDLE) && !mem_busy;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;

	assign wr_in_range = (32'(pixel_x) < IMAGE_WIDTH) && (32'(pixel_y) < IMAGE_HEIGHT);

	// neighbour address for the ring position now being issued
	always_comb begin
		dx = ring_dx(ring_d_q);
		dy = ring_dy(ring_d_q);
		nx = cur_x_q + {{(XW-2){dx[1]}}, dx};
		ny = cur_y_q + {{(YW-2){dy[1]}}, dy};
		n_inb = !((dx == -2'sd1) && (cur_x_q == '0))
			&& !((dx == 2'sd1) && (cur_x_q == XW'(IMAGE_WIDTH - 1)))
			&& !((dy == -2'sd1) && (cur_y_q == '0))
			&& !((dy == 2'sd1) && (cur_y_q == YW'(IMAGE_HEIGHT - 1)));
	end

	assign scan_last_now = (scan_x_q == XW'(IMAGE_WIDTH - 1))
		&& (scan_y_q == YW'(IMAGE_HEIGHT - 1));

	// ring check stage: a hit moves the trace, the eighth miss leaves it in place
	assign ring_hit = ring_vld_s1 && ring_inb_s1 && mem_rd_data;
	assign new_x    = ring_hit ? ring_x_s1 : cur_x_q;
	assign new_y    = ring_hit ? ring_y_s1 : cur_y_q;

	assign mem_rd_addr = (st_q == S_SCAN) ? addr_of(scan_x_q, scan_y_q) : addr_of(nx, ny);

	always_comb begin
		mem_wr.en   = in_fire && (operation == OP_WRITE) && wr_in_range;
		mem_wr.addr = addr_of(XW'(pixel_x), YW'(pixel_y));
		mem_wr.data = pixel_on;
	end

	mbt_pixel_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.busy    (mem_busy)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			phase_q      <= PH_IDLE;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			bt_q         <= DIR_LEFT;
			scan_vld_s1  <= 1'b0;
			ring_vld_s1  <= 1'b0;
			ring_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// emit loads the output register once it is free or draining
			if ((st_q == S_EMIT) && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_fire)
				out_valid_q <= 1'b0;

			case (st_q)
				S_IDLE: begin
					if (in_fire) begin
						if (operation == OP_WRITE) begin
							phase_q <= PH_IDLE;
						end else begin
							case (phase_q)
								PH_DONE:  st_q <= S_EMIT;
								PH_TRACE: begin
									ring_cnt_q  <= '0;
									ring_vld_s1 <= 1'b0;
									st_q        <= S_RING;
								end
								default: begin
									scan_vld_s1 <= 1'b0;
									st_q        <= S_SCAN;
								end
							endcase
						end
					end
				end

				S_SCAN: begin
					if (scan_vld_s1 && mem_rd_data) begin
						scan_vld_s1 <= 1'b0;
						if (scan_x_s1 == '0 && scan_y_s1 == '0) begin
							st_q <= S_EMIT;
						end else begin
							start_x_q   <= scan_x_s1;
							start_y_q   <= scan_y_s1;
							cur_x_q     <= scan_x_s1;
							cur_y_q     <= scan_y_s1;
							bt_q        <= (scan_x_s1 == '0) ? DIR_TOP : DIR_LEFT;
							phase_q     <= PH_TRACE;
							ring_cnt_q  <= '0;
							ring_vld_s1 <= 1'b0;
							st_q        <= S_RING;
						end
					end else if (scan_vld_s1 && scan_last_s1) begin
						scan_vld_s1 <= 1'b0;
						st_q        <= S_EMIT;
					end else begin
						scan_vld_s1 <= 1'b1;
					end
				end

				S_RING: begin
					if (ring_vld_s1 && (ring_hit || ring_last_s1)) begin
						ring_vld_s1 <= 1'b0;
						cur_x_q     <= new_x;
						cur_y_q     <= new_y;
						if (ring_hit)
							bt_q <= next_back(ring_d_s1);
						if (new_x == start_x_q && new_y == start_y_q)
							phase_q <= PH_DONE;
						st_q <= S_EMIT;
					end else if (ring_cnt_q != RING_CNT_W'(8)) begin
						ring_vld_s1 <= 1'b1;
						ring_cnt_q  <= ring_cnt_q + 1'b1;
					end else begin
						ring_vld_s1 <= 1'b0;
					end
				end

				S_EMIT: begin
					if (!out_valid_q || out_ready)
						st_q <= S_IDLE;
				end

				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				scan_x_q <= '0;
				scan_y_q <= '0;
				ring_d_q <= bt_q;
				// a finished trace answers without a point
				res_x_q    <= '0;
				res_y_q    <= '0;
				res_last_q <= 1'b0;
				res_stat_q <= ST_FINISHED;
			end

			S_SCAN: begin
				scan_x_s1    <= scan_x_q;
				scan_y_s1    <= scan_y_q;
				scan_last_s1 <= scan_last_now;
				if (scan_x_q == XW'(IMAGE_WIDTH - 1)) begin
					scan_x_q <= '0;
					scan_y_q <= (scan_y_q == YW'(IMAGE_HEIGHT - 1)) ? '0 : scan_y_q + 1'b1;
				end else begin
					scan_x_q <= scan_x_q + 1'b1;
				end
				ring_d_q   <= (scan_x_s1 == '0) ? DIR_TOP : DIR_LEFT;
				res_x_q    <= '0;
				res_y_q    <= '0;
				res_last_q <= 1'b0;
				res_stat_q <= (scan_vld_s1 && mem_rd_data) ? ST_TOPLEFT : ST_EMPTY;
			end

			S_RING: begin
				ring_d_s1    <= ring_d_q;
				ring_x_s1    <= nx;
				ring_y_s1    <= ny;
				ring_inb_s1  <= n_inb;
				ring_last_s1 <= (ring_cnt_q == RING_CNT_W'(7));
				ring_d_q     <= ring_d_q + 1'b1;
				// point emitted is the one before the move
				res_x_q    <= PT_W'(cur_x_q);
				res_y_q    <= PT_W'(cur_y_q);
				res_last_q <= (new_x == start_x_q) && (new_y == start_y_q);
				res_stat_q <= ST_OK;
			end

			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					point_x_q    <= res_x_q;
					point_y_q    <= res_y_q;
					last_point_q <= res_last_q;
					status_q     <= res_stat_q;
				end
			end

			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign point_x    = point_x_q;
	assign point_y    = point_y_q;
	assign last_point = last_point_q;
	assign status     = status_q;

	`MBT_ASSERT_IMPL(a_start_not_origin, phase_q != PH_IDLE,
		(start_x_q != '0) || (start_y_q != '0), "trace started at top-left pixel")
	`MBT_ASSERT_IMPL(a_ring_count, st_q == S_RING, ring_cnt_q <= RING_CNT_W'(8),
		"ring scan ran past eight neighbours")
	`MBT_ASSERT_IMPL(a_cur_in_image, phase_q == PH_TRACE,
		(32'(cur_x_q) < IMAGE_WIDTH) && (32'(cur_y_q) < IMAGE_HEIGHT),
		"trace point left the image")
	`MBT_ASSERT_NEXT(a_result_from_emit, !out_valid_q || out_ready,
		out_valid_q == $past(st_q == S_EMIT), "result beat not sourced by emit state")

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for moore_boundary_tracer: pixel writes and contour steps over
// valid/ready channels, checked against a behavioral tracer held in a scoreboard class.
// Depends on mbt_pkg and the moore_boundary_tracer RTL.

module tb;
	import mbt_pkg::*;

	// generous: far above any expected run
	localparam int unsigned CYCLE_LIMIT = 25_000_000;
	localparam int RANDOM_BEATS = 850;

	typedef struct {
		logic [5:0] x;
		logic [5:0] y;
		logic       last;
		logic [1:0] st;
	} contour_pt_t;

	// Behavioral tracer plus the queue of points still owed by the block.
	class trace_scoreboard;
		bit          image [IMG_DEPTH];
		logic [5:0]  cur_x, cur_y, org_x, org_y;
		logic [2:0]  back_dir;
		phase_t      phase;
		contour_pt_t pending [$];
		int          step_dx [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
		int          step_dy [8] = '{0, -1, -1, -1, 0, 1, 1, 1};
		int          mismatches, points_seen, loops_closed;
		int          empty_seen, corner_seen, done_seen;

		function new();
			foreach (image[i]) image[i] = 1'b0;
			cur_x = '0; cur_y = '0; org_x = '0; org_y = '0;
			back_dir = DIR_LEFT;
			phase = PH_IDLE;
		endfunction

		// outside the image reads as background
		function bit lit(int x, int y);
			if (x < 0 || y < 0 || x >= IMAGE_WIDTH || y >= IMAGE_HEIGHT)
				return 1'b0;
			return image[y * IMAGE_WIDTH + x];
		endfunction

		// queue one owed point behind the others
		function void owe_point(contour_pt_t p);
			pending = {pending, p};
		endfunction

		function void note_beat(logic op, logic [5:0] x, logic [5:0] y, logic on);
			contour_pt_t p;
			int first, d, cx, cy, nx, ny;
			if (op == OP_WRITE) begin
				image[int'(y) * IMAGE_WIDTH + int'(x)] = on;
				phase = PH_IDLE;
				return;
			end
			p = '{x: '0, y: '0, last: 1'b0, st: ST_OK};
			if (phase == PH_DONE) begin
				p.st = ST_FINISHED;
				owe_point(p);
				return;
			end
			if (phase == PH_IDLE) begin
				// raster walk for the first foreground pixel
				first = -1;
				for (int i = 0; i < IMG_DEPTH && first < 0; i++)
					if (image[i]) first = i;
				if (first < 0) begin
					p.st = ST_EMPTY;
					owe_point(p);
					return;
				end
				if (first == 0) begin
					p.st = ST_TOPLEFT;
					owe_point(p);
					return;
				end
				org_x = 6'(first % IMAGE_WIDTH);
				org_y = 6'(first / IMAGE_WIDTH);
				cur_x = org_x;
				cur_y = org_y;
				back_dir = (org_x == 0) ? DIR_TOP : DIR_LEFT;
				phase = PH_TRACE;
			end
			p.x = cur_x;
			p.y = cur_y;
			cx = int'(cur_x);
			cy = int'(cur_y);
			d = int'(back_dir);
			// clockwise from the backtrack; new backtrack is the even slot behind the hit
			for (int k = 0; k < 8; k++) begin
				nx = cx + step_dx[d];
				ny = cy + step_dy[d];
				if (lit(nx, ny)) begin
					cur_x = 6'(nx);
					cur_y = 6'(ny);
					back_dir = 3'(((d & 6) + 6) % 8);
					break;
				end
				d = (d + 1) % 8;
			end
			if (cur_x == org_x && cur_y == org_y) begin
				phase = PH_DONE;
				p.last = 1'b1;
			end
			owe_point(p);
		endfunction

		task report(string what, int got, int want);
			mismatches++;
			if (mismatches <= 20)
				$display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
		endtask

		task check_point(contour_pt_t got);
			contour_pt_t want;
			if (pending.size() == 0) begin
				report("unexpected point (status)", got.st, -1);
				return;
			end
			want = pending.pop_front();
			if (got.x !== want.x) report("point_x", got.x, want.x);
			if (got.y !== want.y) report("point_y", got.y, want.y);
			if (got.last !== want.last) report("last_point", got.last, want.last);
			if (got.st !== want.st) report("status", got.st, want.st);
			points_seen++;
			case (want.st)
				ST_EMPTY:    empty_seen++;
				ST_TOPLEFT:  corner_seen++;
				ST_FINISHED: done_seen++;
				default:     if (want.last) loops_closed++;
			endcase
		endtask
	endclass

	logic       clk, arst_n;
	logic       in_valid, in_ready;
	logic       operation, pixel_on;
	logic [5:0] pixel_x, pixel_y;
	logic       out_valid, out_ready;
	logic [5:0] point_x, point_y;
	logic       last_point;
	logic [1:0] status;

	trace_scoreboard sb = new();
	int unsigned     cycle_count;
	int              beats_sent;
	bit              calm;   // set for stretches with no input gaps

	moore_boundary_tracer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.pixel_on  (pixel_on),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.point_x   (point_x),
		.point_y   (point_y),
		.last_point(last_point),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d points owed", cycle_count,
				sb.pending.size());
			$display("status: fail");
			$finish;
		end
	end

	// result side: every accepted beat is compared with the oldest owed point
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_point('{x: point_x, y: point_y, last: last_point, st: status});
	end

	// Receiver stalls: runs of ready, then a hold-off that is mostly short.
	initial begin
		int run, r;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 40);
			repeat (run) @(negedge clk) out_ready <= 1'b1;
			r = $urandom_range(0, 99);
			if (r < 40)      run = 0;
			else if (r < 80) run = $urandom_range(1, 3);
			else if (r < 95) run = $urandom_range(4, 12);
			else             run = $urandom_range(20, 60);
			repeat (run) @(negedge clk) out_ready <= 1'b0;
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Drives one beat at the falling edge and returns at the edge that takes it.
	// The model is updated here, so stimulus can steer on the traced phase.
	task automatic send_beat(logic op, logic [5:0] x, logic [5:0] y, logic on);
		int gap;
		gap = pick_gap();
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid  <= 1'b1;
		operation <= op;
		pixel_x   <= x;
		pixel_y   <= y;
		pixel_on  <= on;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(op, x, y, on);
		beats_sent++;
	endtask

	task automatic write_pixel(int x, int y, logic on);
		send_beat(OP_WRITE, 6'(x), 6'(y), on);
	endtask

	// pixel fields are don't-care on a step; toggle them anyway
	task automatic step_once();
		send_beat(OP_STEP, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
			1'($urandom_range(0, 1)));
	endtask

	// steps until the loop closes or an error status; cap guards against open loops
	task automatic trace_contour(int cap, int extra);
		for (int i = 0; i < cap; i++) begin
			step_once();
			if (sb.phase != PH_TRACE) break;
		end
		if (sb.phase == PH_DONE)
			repeat (extra) step_once();
	endtask

	task automatic clear_image();
		for (int i = 0; i < IMG_DEPTH; i++)
			if (sb.image[i]) write_pixel(i % IMAGE_WIDTH, i / IMAGE_WIDTH, 1'b0);
	endtask

	// small cluster, biased toward the top rows so the raster walk stays short,
	// and toward the left and right columns to hit the edge cases
	task automatic draw_blob(output int ox, output int oy, output int span);
		int r, n, x, y;
		r = $urandom_range(0, 99);
		if (r < 25)      ox = 0;
		else if (r < 40) ox = $urandom_range(59, 63);
		else             ox = $urandom_range(0, 63);
		oy = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(0, 63);
		span = $urandom_range(2, 5);
		n = $urandom_range(1, 10);
		for (int k = 0; k < n; k++) begin
			x = ox + $urandom_range(0, span - 1);
			y = oy + $urandom_range(0, span - 1);
			if (x < IMAGE_WIDTH && y < IMAGE_HEIGHT)
				write_pixel(x, y, 1'($urandom_range(0, 5) != 0));   // a few holes
		end
	endtask

	initial begin
		int ox, oy, span, r, n, x, y;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = OP_WRITE;
		pixel_x   = '0;
		pixel_y   = '0;
		pixel_on  = 1'b0;
		calm      = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// ---- directed ----
		step_once();                  // nothing drawn: empty image
		write_pixel(0, 0, 1'b1);
		step_once();                  // first pixel at the top-left corner
		write_pixel(0, 0, 1'b0);
		write_pixel(63, 63, 1'b1);    // last raster slot, full walk
		step_once();                  // lone pixel closes at once
		step_once();                  // trace already finished
		write_pixel(0, 5, 1'b1);      // column-0 start, backtrack from above
		write_pixel(1, 5, 1'b1);
		write_pixel(1, 6, 1'b1);
		trace_contour(12, 1);
		write_pixel(62, 0, 1'b1);     // top row against the right edge
		write_pixel(63, 0, 1'b1);
		write_pixel(63, 1, 1'b1);
		step_once();
		write_pixel(63, 63, 1'b0);    // write mid-trace restarts the trace
		trace_contour(12, 1);
		clear_image();

		// ---- random ----
		while (beats_sent < 25 + RANDOM_BEATS) begin
			calm = ($urandom_range(0, 5) == 0);
			clear_image();
			r = $urandom_range(0, 99);
			if (r < 78) begin
				draw_blob(ox, oy, span);
				trace_contour(80, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0);
			end else if (r < 90) begin
				// broken trace: an edit lands partway round
				draw_blob(ox, oy, span);
				trace_contour($urandom_range(1, 4), 0);
				x = ox + $urandom_range(0, span);
				y = oy + $urandom_range(0, span);
				if (x > 63) x = 63;
				if (y > 63) y = 63;
				write_pixel(x, y, 1'($urandom_range(0, 1)));
				trace_contour(80, $urandom_range(0, 1));
			end else begin
				// noise anywhere in the image
				n = $urandom_range(1, 4);
				repeat (n)
					send_beat(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
						6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			end
		end
		@(negedge clk) in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);   // a late extra point would show up here
		if (sb.pending.size() != 0)
			sb.report("points never returned", sb.pending.size(), 0);

		$display("%0d beats in, %0d points checked: %0d closed loops, %0d empty,",
			beats_sent, sb.points_seen, sb.loops_closed, sb.empty_seen);
		$display("%0d top-left starts, %0d steps past the end, %0d mismatches",
			sb.corner_seen, sb.done_seen, sb.mismatches);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
